@@ rtl/core/att_pkg.sv @@
// Shared constants for the allocation tracking table.
// Operation and status codes, field widths and stream layout.
// No dependencies.
package att_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int LIVE_W = 13;
  localparam int CNT_W  = 32;

  localparam int S_TDATA_W = 88;   // 82 bits of fields, padded to bytes
  localparam int M_TDATA_W = 112;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  localparam logic [1:0] REG_MARK_ONLY = 2'd0;

endpackage

@@ rtl/core/att_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the bucket heads and the entry records. No dependencies.
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/att_ctrl.sv @@
// Sequencer for the allocation tracking table: hashing, chain walk,
// free list and counters. Owns the bucket and entry RAMs (att_ram).
// Depends on att_pkg.
module att_ctrl
  import att_pkg::*;
#(
  parameter int BUCKETS    = 1024,
  parameter int ENTRIES    = 4096,
  parameter int HASH_SHIFT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mark_only,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [SIZE_W-1:0] in_block_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [SIZE_W-1:0] out_found_size,
  output logic              out_was_deleted,
  output logic [LIVE_W-1:0] out_live_blocks,
  output logic [CNT_W-1:0]  out_live_bytes,
  output logic [CNT_W-1:0]  out_total_adds
);

  localparam int IW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int BW = $clog2(BUCKETS);
  localparam logic [IW-1:0] END_IDX = IW'(ENTRIES);
  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  // entry record: {next, address, size, deleted}
  localparam int SZ_LO = 1;
  localparam int AD_LO = SZ_LO + SIZE_W;
  localparam int NX_LO = AD_LO + ADDR_W;
  localparam int EW = NX_LO + IW;
  // remainder for other bucket counts: Horner over 16-bit key digits, each
  // step reduced by reciprocal multiplication (quotient low by at most one)
  localparam int KDW = 48;
  localparam int ND = KDW / 16;
  localparam logic [31:0] MINV = 32'((64'd1 << 32) / BUCKETS);
  localparam logic [31:0] BK = 32'(BUCKETS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BRD, S_BHEAD, S_AFREE, S_ALINK, S_WALK, S_FREE, S_DONE
  } state_t;

  state_t            state;
  logic [1:0]        func;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] block_size;
  logic [KDW-1:0]    key_sh;
  logic [15:0]       rem;
  logic [1:0]        hcnt;
  logic              hph;
  logic [63:0]       hprod;
  logic [BW-1:0]     clr;
  logic [IW-1:0]     cur;
  logic [IW-1:0]     prev;
  logic [EW-1:0]     prev_rec;
  logic [IW-1:0]     free_head;
  logic [IW-1:0]     fill;
  logic [IW-1:0]     blocks;
  logic [CNT_W-1:0]  bytes;
  logic [CNT_W-1:0]  adds;
  logic [1:0]        res_status;
  logic [SIZE_W-1:0] res_found;
  logic              res_del;

  logic [BW-1:0]     bucket;
  logic [31:0]       hx;
  logic [31:0]       hq;
  logic [31:0]       hrem;
  logic [15:0]       rem_next;

  logic              b_we;
  logic [BW-1:0]     b_waddr;
  logic [IW-1:0]     b_wdata;
  logic [IW-1:0]     b_rdata;
  logic              e_we;
  logic [IW-1:0]     e_waddr;
  logic [EW-1:0]     e_wdata;
  logic [IW-1:0]     e_raddr;
  logic [EW-1:0]     e_rdata;

  logic [IW-1:0]     rec_next;
  logic [ADDR_W-1:0] rec_addr;
  logic [SIZE_W-1:0] rec_size;
  logic              rec_del;
  logic              rec_hit;

  assign rec_next = e_rdata[NX_LO +: IW];
  assign rec_addr = e_rdata[AD_LO +: ADDR_W];
  assign rec_size = e_rdata[SZ_LO +: SIZE_W];
  assign rec_del  = e_rdata[0];
  assign rec_hit  = rec_addr == address;

  assign bucket   = POW2 ? address[HASH_SHIFT +: BW] : BW'(rem);
  assign in_ready = state == S_IDLE;

  assign hx       = {rem, key_sh[KDW-1 -: 16]};
  assign hq       = hprod[63:32];
  assign hrem     = hx - hq * BK;
  assign rem_next = (hrem >= BK) ? 16'(hrem - BK) : 16'(hrem);

  always_comb begin
    b_we    = 1'b0;
    b_waddr = bucket;
    b_wdata = cur;
    e_we    = 1'b0;
    e_waddr = cur;
    e_wdata = {prev, address, block_size, 1'b0};
    e_raddr = cur;
    case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr;
        b_wdata = END_IDX;
      end
      S_BHEAD: begin
        e_raddr = (func == FUNC_ADD) ? free_head : b_rdata;
      end
      S_ALINK: begin
        // prev holds the old chain head here
        b_we = 1'b1;
        e_we = 1'b1;
      end
      S_WALK: begin
        e_raddr = rec_next;
        if (rec_hit && func == FUNC_REMOVE) begin
          if (mark_only) begin
            e_we    = 1'b1;
            e_wdata = {e_rdata[EW-1:1], 1'b1};
          end else if (prev == END_IDX) begin
            b_we    = 1'b1;
            b_wdata = rec_next;
          end else begin
            e_we    = 1'b1;
            e_waddr = prev;
            e_wdata = {rec_next, prev_rec[NX_LO-1:0]};
          end
        end
      end
      S_FREE: begin
        e_we    = 1'b1;
        e_wdata = {free_head, (NX_LO)'(0)};
      end
      default: begin
      end
    endcase
  end

  att_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (bucket),
    .rdata (b_rdata)
  );

  att_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr[AW-1:0]),
    .wdata (e_wdata),
    .raddr (e_raddr[AW-1:0]),
    .rdata (e_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_head <= END_IDX;
      fill      <= '0;
      blocks    <= '0;
      bytes     <= '0;
      adds      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func       <= in_func;
            address    <= in_address;
            block_size <= in_block_size;
            key_sh     <= in_address >> HASH_SHIFT;
            rem        <= '0;
            hcnt       <= '0;
            hph        <= 1'b0;
            res_status <= ST_NOT_FOUND;
            res_found  <= '0;
            res_del    <= 1'b0;
            state      <= POW2 ? S_BRD : S_HASH;
          end
        end
        S_HASH: begin
          if (!hph) begin
            hprod <= 64'(hx) * 64'(MINV);
          end else begin
            rem    <= rem_next;
            key_sh <= key_sh << 16;
            hcnt   <= hcnt + 1'b1;
            if (hcnt == 2'(ND - 1)) begin
              state <= S_BRD;
            end
          end
          hph <= !hph;
        end
        S_BRD: begin
          state <= S_BHEAD;
        end
        S_BHEAD: begin
          prev <= (func == FUNC_ADD) ? b_rdata : END_IDX;
          case (func)
            FUNC_ADD: begin
              if (free_head != END_IDX) begin
                cur   <= free_head;
                state <= S_AFREE;
              end else if (fill != END_IDX) begin
                // slots never used yet follow the freed ones
                cur   <= fill;
                fill  <= fill + 1'b1;
                state <= S_ALINK;
              end else begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end
            end
            FUNC_REMOVE, FUNC_LOOKUP: begin
              cur   <= b_rdata;
              state <= (b_rdata == END_IDX) ? S_DONE : S_WALK;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_AFREE: begin
          free_head <= rec_next;
          state     <= S_ALINK;
        end
        S_ALINK: begin
          blocks     <= blocks + 1'b1;
          adds       <= adds + 1'b1;
          bytes      <= bytes + block_size;
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_WALK: begin
          if (rec_hit) begin
            res_status <= ST_OK;
            res_del    <= rec_del;
            if (func == FUNC_LOOKUP) begin
              res_found <= rec_size;
              state     <= S_DONE;
            end else if (mark_only) begin
              state <= S_DONE;
            end else begin
              blocks <= blocks - 1'b1;
              bytes  <= bytes - rec_size;
              state  <= S_FREE;
            end
          end else begin
            prev     <= cur;
            prev_rec <= e_rdata;
            cur      <= rec_next;
            if (rec_next == END_IDX) begin
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          free_head <= cur;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_status      <= res_status;
            out_found_size  <= res_found;
            out_was_deleted <= res_del;
            out_live_blocks <= LIVE_W'(blocks);
            out_live_bytes  <= bytes;
            out_total_adds  <= adds;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/allocation_tracking_table.sv @@
// Allocation tracking table: chained hash table of live blocks.
// Slave stream takes requests, master stream returns one result per request.
// The mark-only register sits on an APB port at byte address 0.
//
// Steps from accept to result valid, paced by the entry RAM's single read port:
//   add            bucket read, head, link, done (a free-list read before
//                  the link when reusing a slot; from head to done if full)
//   lookup         bucket read, head, a walk step per chain entry read up to the match, done
//   remove         as lookup, plus a free step when the entry is unlinked
//   unused func    bucket read, head, done
// A bucket count that is not a power of two adds a remainder step before
// the bucket read, a multiply and a reduce per 16-bit key digit. One
// request is in flight at a time; the next is taken once the result has
// moved to the output register. After reset the bucket RAM is cleared, one
// bucket a cycle, s_tready low till all BUCKETS (1024 by default) are done;
// APB writes work throughout. A stalled result holds in the output register
// and the following request waits in the sequencer until it can be handed over.
// Depends on att_pkg, att_ctrl, att_ram.
module allocation_tracking_table
  import att_pkg::*;
#(
  parameter int BUCKETS    = 1024,
  parameter int ENTRIES    = 4096,
  parameter int HASH_SHIFT = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // func[1:0], address[49:2], block_size[81:50]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[1:0], found_size[33:2], was_deleted[34], live_blocks[47:35],
  // live_bytes[79:48], total_adds[111:80]
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic              mark_only;
  logic [1:0]        out_status;
  logic [SIZE_W-1:0] out_found_size;
  logic              out_was_deleted;
  logic [LIVE_W-1:0] out_live_blocks;
  logic [CNT_W-1:0]  out_live_bytes;
  logic [CNT_W-1:0]  out_total_adds;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MARK_ONLY) ? {31'b0, mark_only} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_only <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_MARK_ONLY) begin
      mark_only <= pwdata[0];
    end
  end

  att_ctrl #(
    .BUCKETS    (BUCKETS),
    .ENTRIES    (ENTRIES),
    .HASH_SHIFT (HASH_SHIFT)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .mark_only       (mark_only),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_func         (s_tdata[1:0]),
    .in_address      (s_tdata[49:2]),
    .in_block_size   (s_tdata[81:50]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (out_status),
    .out_found_size  (out_found_size),
    .out_was_deleted (out_was_deleted),
    .out_live_blocks (out_live_blocks),
    .out_live_bytes  (out_live_bytes),
    .out_total_adds  (out_total_adds)
  );

  assign m_tdata = {out_total_adds, out_live_bytes, out_live_blocks,
                    out_was_deleted, out_found_size, out_status};

endmodule

@@ rtl/core/att_checker.sv @@
// Port-level checks for allocation_tracking_table, bound to the top level.
// Depends on att_pkg.
module att_checker
  import att_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // only a successful lookup reports a size
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:2] != 32'd0 |-> m_tdata[1:0] == ST_OK)
    else $error("size reported on failed operation");

  // a full table reports no match data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |-> !m_tdata[34] && m_tdata[33:2] == 32'd0)
    else $error("match data on full-table result");

  // total adds never moves by more than one between beats
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready ##1 m_tvalid |->
      m_tdata[111:80] == $past(m_tdata[111:80]) ||
      m_tdata[111:80] == $past(m_tdata[111:80]) + 32'd1)
    else $error("add counter jumped");

endmodule

bind allocation_tracking_table att_checker u_att_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
